// ===== hdl/header_length_xor_deframer_unit_defines.svh =====
// Assertion macros for the deframer top-level RTL file.
`ifndef HEADER_LENGTH_XOR_DEFRAMER_UNIT_DEFINES_SVH
`define HEADER_LENGTH_XOR_DEFRAMER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clk, idle while in reset.
`define HLXD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hlxd same-cycle check failed");

// Next-cycle implication, checked on clk, idle while in reset.
`define HLXD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hlxd next-cycle check failed");

`endif

// ===== hdl/hlxd_pkg.sv =====
// Package: constants and types of the header/length/XOR deframer.
package hlxd_pkg;

    localparam int BYTE_W = 8;

    // Frame marker characters
    localparam logic [BYTE_W-1:0] CH_U     = 8'h55;
    localparam logic [BYTE_W-1:0] CH_N     = 8'h4E;
    localparam logic [BYTE_W-1:0] CH_E     = 8'h45;
    localparam logic [BYTE_W-1:0] CH_R     = 8'h52;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;

    // XOR of the fixed header and separator bytes
    localparam logic [BYTE_W-1:0] HDR_XOR = CH_U ^ CH_N ^ CH_E ^ CH_R ^ CH_COLON;

    // Parser phases, one-hot
    typedef enum logic [6:0] {
        PH_HUNT     = 7'b0000001,
        PH_WANT_N   = 7'b0000010,
        PH_WANT_E   = 7'b0000100,
        PH_WANT_R   = 7'b0001000,
        PH_TAKE_LEN = 7'b0010000,
        PH_WANT_COL = 7'b0100000,
        PH_PAYLOAD  = 7'b1000000
    } phase_t;

endpackage

// ===== hdl/hlxd_if.sv =====
// Valid/ready channel interfaces for received bytes and frame results.
interface hlxd_rx_if;
    logic                         valid;
    logic                         ready;
    logic [hlxd_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hlxd_res_if;
    logic                         valid;
    logic                         ready;
    logic [hlxd_pkg::BYTE_W-1:0]  data_byte;
    logic                         frame_end;
    logic                         frame_good;

    modport source (output valid, output data_byte, output frame_end, output frame_good,
                    input ready);
    modport sink   (input valid, input data_byte, input frame_end, input frame_good,
                    output ready);
endinterface

// ===== hdl/header_length_xor_deframer_unit.sv =====
// Header/length/XOR-checksum frame parser, top level.
//
// Usage:
//   rx    : sink channel, one received byte per transfer (valid/ready).
//   frame : source channel, one result per payload byte (frame_end = 0)
//           and one end result per checksum byte (frame_end = 1,
//           frame_good = checksum match). Header, length and ':' bytes,
//           and bytes seen while hunting, give no result.
//   Path: a transferred byte is held in the input register, parsed from
//   there into the result register and offered on the frame channel.
//   Throughput: one byte per cycle while no result-producing byte is held
//   back by frame, set by the single parse step between the two registers.
//   Stall: while a result waits on frame, the next byte still parses if
//   it makes no result; a result-producing byte waits in the input
//   register and rx.ready drops only when that register cannot drain.
//   Reset: parser hunts for 'U', count and checksum cleared, both
//   pipeline registers empty.
module header_length_xor_deframer_unit (
    input  logic              clk,
    input  logic              rst_n,
    hlxd_rx_if.sink           rx,
    hlxd_res_if.source        frame
);

`include "header_length_xor_deframer_unit_defines.svh"

    // Input register
    logic                         in_valid_reg;
    logic [hlxd_pkg::BYTE_W-1:0]  in_byte_reg;

    // Parser state
    hlxd_pkg::phase_t             phase_reg, phase_next;
    logic [hlxd_pkg::BYTE_W-1:0]  bytes_left_reg, bytes_left_next;
    logic [hlxd_pkg::BYTE_W-1:0]  xor_reg, xor_next;

    // Result register
    logic                         out_valid_reg;
    logic [hlxd_pkg::BYTE_W-1:0]  out_byte_reg;
    logic                         out_end_reg;
    logic                         out_good_reg;

    // Parse step outputs
    logic                         res_load;
    logic                         res_end;
    logic                         res_good;
    logic [hlxd_pkg::BYTE_W-1:0]  left_dec;
    hlxd_pkg::phase_t             hunt_phase;
    logic                         out_free;
    logic                         advance;

    // Handshake control
    assign out_free = !out_valid_reg || frame.ready;
    assign advance  = in_valid_reg && (!res_load || out_free);
    assign rx.ready = !in_valid_reg || advance;

    // Parse step
    always_comb
    begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        xor_next        = xor_reg;
        res_load        = 1'b0;
        res_end         = 1'b0;
        res_good        = 1'b0;
        left_dec        = bytes_left_reg - 8'd1;
        hunt_phase      = (in_byte_reg == hlxd_pkg::CH_U) ? hlxd_pkg::PH_WANT_N
                                                          : hlxd_pkg::PH_HUNT;
        unique case (phase_reg)
            hlxd_pkg::PH_WANT_N:
            begin
                phase_next = (in_byte_reg == hlxd_pkg::CH_N) ? hlxd_pkg::PH_WANT_E
                                                             : hunt_phase;
            end
            hlxd_pkg::PH_WANT_E:
            begin
                phase_next = (in_byte_reg == hlxd_pkg::CH_E) ? hlxd_pkg::PH_WANT_R
                                                             : hunt_phase;
            end
            hlxd_pkg::PH_WANT_R:
            begin
                phase_next = (in_byte_reg == hlxd_pkg::CH_R) ? hlxd_pkg::PH_TAKE_LEN
                                                             : hunt_phase;
            end
            hlxd_pkg::PH_TAKE_LEN:
            begin
                bytes_left_next = in_byte_reg;
                phase_next      = hlxd_pkg::PH_WANT_COL;
            end
            hlxd_pkg::PH_WANT_COL:
            begin
                if (in_byte_reg == hlxd_pkg::CH_COLON)
                begin
                    phase_next = hlxd_pkg::PH_PAYLOAD;
                    xor_next   = hlxd_pkg::HDR_XOR ^ bytes_left_reg;
                end
                else
                begin
                    phase_next = hunt_phase;
                end
            end
            hlxd_pkg::PH_PAYLOAD:
            begin
                // count wraps: a length of zero carries 255 payload bytes
                bytes_left_next = left_dec;
                res_load        = 1'b1;
                if (left_dec != 8'd0)
                begin
                    xor_next = xor_reg ^ in_byte_reg;
                end
                else
                begin
                    phase_next = hlxd_pkg::PH_HUNT;
                    res_end    = 1'b1;
                    res_good   = (xor_reg == in_byte_reg);
                end
            end
            default:
            begin
                phase_next = hunt_phase;
            end
        endcase
    end

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.valid && rx.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_byte_reg <= rx.rx_byte;
        end
    end

    // Parser state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= hlxd_pkg::PH_HUNT;
            bytes_left_reg <= '0;
            xor_reg        <= '0;
        end
        else if (advance)
        begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            xor_reg        <= xor_next;
        end
    end

    // Result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (frame.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (advance && res_load)
        begin
            out_byte_reg <= in_byte_reg;
            out_end_reg  <= res_end;
            out_good_reg <= res_good;
        end
    end

    assign frame.valid      = out_valid_reg;
    assign frame.data_byte  = out_byte_reg;
    assign frame.frame_end  = out_end_reg;
    assign frame.frame_good = out_good_reg;

    // Checks
    `HLXD_ASSERT_NEXT(a_end_returns_hunt,
        advance && res_end, phase_reg == hlxd_pkg::PH_HUNT)
    `HLXD_ASSERT_NOW(a_good_only_on_end,
        out_valid_reg && !out_end_reg, !out_good_reg)
    `HLXD_ASSERT_NEXT(a_result_held_on_stall,
        out_valid_reg && !frame.ready, out_valid_reg && $stable(out_byte_reg))
    `HLXD_ASSERT_NEXT(a_input_held_on_block,
        in_valid_reg && !advance, in_valid_reg && $stable(in_byte_reg))

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the header/length/XOR-checksum frame parser.
module testbench;
    import hlxd_pkg::*;

    typedef logic [BYTE_W-1:0] byte_t;

    // One frame-channel result: payload byte or end-of-frame verdict
    typedef struct packed {
        byte_t data_byte;
        logic  frame_end;
        logic  frame_good;
    } frame_result_t;

    // Tracks the parser state from accepted bytes and checks the results
    class frame_checker;
        phase_t        phase;
        byte_t         remaining;
        byte_t         frame_xor;
        frame_result_t expected_q[$];
        int            errors;
        int            results_seen;

        function new();
            phase        = PH_HUNT;
            remaining    = '0;
            frame_xor    = '0;
            errors       = 0;
            results_seen = 0;
        endfunction

        // A mismatching byte is retried as the start of a new header
        function phase_t hunt_from(byte_t b);
            if (b == CH_U)
                return PH_WANT_N;
            return PH_HUNT;
        endfunction

        function void note_rx(byte_t b);
            frame_result_t res;
            res = '0;
            case (phase)
                PH_WANT_N:   phase = (b == CH_N) ? PH_WANT_E : hunt_from(b);
                PH_WANT_E:   phase = (b == CH_E) ? PH_WANT_R : hunt_from(b);
                PH_WANT_R:   phase = (b == CH_R) ? PH_TAKE_LEN : hunt_from(b);
                PH_TAKE_LEN:
                begin
                    remaining = b;
                    phase     = PH_WANT_COL;
                end
                PH_WANT_COL:
                begin
                    if (b == CH_COLON)
                    begin
                        phase     = PH_PAYLOAD;
                        frame_xor = CH_U ^ CH_N ^ CH_E ^ CH_R ^ CH_COLON ^ remaining;
                    end
                    else
                        phase = hunt_from(b);
                end
                PH_PAYLOAD:
                begin
                    // count is 8 bits: a length of zero wraps to 255 payload bytes
                    remaining     = remaining - 8'd1;
                    res.data_byte = b;
                    if (remaining != 0)
                        frame_xor = frame_xor ^ b;
                    else
                    begin
                        phase          = PH_HUNT;
                        res.frame_end  = 1'b1;
                        res.frame_good = (frame_xor == b);
                    end
                    expected_q.push_back(res);
                end
                default:     phase = hunt_from(b);
            endcase
        endfunction

        function void check_result(frame_result_t got);
            frame_result_t want;
            results_seen++;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h/%b/%b", $time,
                         got.data_byte, got.frame_end, got.frame_good);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.data_byte !== want.data_byte)
            begin
                $display("%0t: data_byte mismatch, expected %h, actual %h", $time,
                         want.data_byte, got.data_byte);
                errors++;
            end
            if (got.frame_end !== want.frame_end)
            begin
                $display("%0t: frame_end mismatch, expected %b, actual %b", $time,
                         want.frame_end, got.frame_end);
                errors++;
            end
            if (got.frame_good !== want.frame_good)
            begin
                $display("%0t: frame_good mismatch, expected %b, actual %b", $time,
                         want.frame_good, got.frame_good);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    bit           calm;
    int           stream_items;
    byte_t        seq_q[$];
    frame_checker chk;

    hlxd_rx_if  rx_ch ();
    hlxd_res_if res_ch ();

    header_length_xor_deframer_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .frame (res_ch)
    );

    // 10-unit clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    function automatic byte_t pick_len();
        int r;
        r = $urandom_range(0, 199);
        if (r < 1)
            return 8'd0;
        else if (r < 2)
            return 8'd255;
        else if (r < 25)
            return 8'd1;
        else if (r < 150)
            return byte_t'($urandom_range(2, 8));
        return byte_t'($urandom_range(9, 40));
    endfunction

    // One byte transfer on rx; called just after a rising edge
    task automatic send_byte(input byte_t b, input bit counted);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (rx_ch.ready !== 1'b1);
        chk.note_rx(b);
        if (counted)
            stream_items++;
    endtask

    task automatic send_list(input byte_t list[$]);
        foreach (list[i])
            send_byte(list[i], 1'b1);
    endtask

    // Well-formed frame, checksum optionally spoiled
    task automatic send_frame(input byte_t len, input bit corrupt);
        byte_t sum;
        byte_t b;
        int    n;
        sum = CH_U ^ CH_N ^ CH_E ^ CH_R ^ CH_COLON ^ len;
        send_byte(CH_U, 1'b1);
        send_byte(CH_N, 1'b1);
        send_byte(CH_E, 1'b1);
        send_byte(CH_R, 1'b1);
        send_byte(len, 1'b1);
        send_byte(CH_COLON, 1'b1);
        n = (len == 0) ? 255 : len - 1;
        repeat (n)
        begin
            b   = byte_t'($urandom);
            sum = sum ^ b;
            send_byte(b, 1'b1);
        end
        if (corrupt)
            sum = sum ^ byte_t'($urandom_range(1, 255));
        send_byte(sum, 1'b1);
    endtask

    // Header cut short by a wrong byte, often a fresh 'U'
    task automatic send_broken();
        byte_t hdr[6];
        byte_t bad;
        int    k;
        hdr = '{CH_U, CH_N, CH_E, CH_R, byte_t'($urandom), CH_COLON};
        k   = $urandom_range(1, 4);
        // the length byte never mismatches, so break at the separator instead
        if (k == 4)
            k = 5;
        for (int i = 0; i < k; i++)
            send_byte(hdr[i], 1'b1);
        do
            bad = $urandom_range(0, 1) ? CH_U : byte_t'($urandom);
        while (bad == hdr[k]);
        send_byte(bad, 1'b1);
    endtask

    // Result side: check transfers, random and long back-pressure
    initial
    begin
        int hold;
        bit long_hold_done;
        hold           = 0;
        long_hold_done = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            frame_result_t got;
            @(posedge clk);
            if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            begin
                got.data_byte  = res_ch.data_byte;
                got.frame_end  = res_ch.frame_end;
                got.frame_good = res_ch.frame_good;
                chk.check_result(got);
            end
            if (!long_hold_done && chk.results_seen >= 100)
            begin
                long_hold_done = 1;
                hold           = 300;
            end
            if (hold > 0)
            begin
                res_ch.ready <= 1'b0;
                hold--;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    hold = pick_gap();
            end
        end
    end

    // Stimulus and final verdict
    initial
    begin
        bit paused;
        int r;
        chk           = new();
        calm          = 0;
        paused        = 0;
        stream_items  = 0;
        rst_n         <= 1'b0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // noise byte 0xFF, repeated 'U', length one with a good checksum
        seq_q = '{8'hFF, CH_U, CH_U, CH_N, CH_E, CH_R, 8'd1, CH_COLON, HDR_XOR ^ 8'd1};
        send_list(seq_q);
        // restart inside the header, then a two-byte frame with a bad checksum
        seq_q = '{CH_U, CH_N, CH_U, CH_N, CH_E, CH_R, 8'd2, CH_COLON, 8'hA5,
                  HDR_XOR ^ 8'd2 ^ 8'hA5 ^ 8'h80};
        send_list(seq_q);
        // separator replaced by 'U', then a wrong 'R' byte of 0x00
        seq_q = '{CH_U, CH_N, CH_E, CH_R, 8'd3, CH_U, CH_N, CH_E, 8'h00};
        send_list(seq_q);

        // length zero wraps to 255 payload bytes
        send_frame(8'd0, 1'b0);

        while (stream_items < 1500)
        begin
            if (!paused && stream_items >= 700)
            begin
                // drain everything before carrying on
                paused = 1;
                rx_ch.valid <= 1'b0;
                @(posedge clk);
                while (chk.pending() != 0)
                    @(posedge clk);
            end
            if ($urandom_range(0, 19) == 0)
                calm = ($urandom_range(0, 99) < 30);
            r = $urandom_range(0, 99);
            if (r < 72)
                send_frame(pick_len(), $urandom_range(0, 3) == 0);
            else if (r < 88)
                send_broken();
            else
                repeat ($urandom_range(1, 4)) send_byte(byte_t'($urandom), 1'b0);
        end

        rx_ch.valid <= 1'b0;
        while (chk.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (chk.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
